// ===== rtl/core/button_debounce_gesture_detector_unit_macros.svh =====
// Assertion macros for the checker file of the button gesture unit.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BUTTON_DEBOUNCE_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_GESTURE_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BDG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BDG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bdg_pkg.sv =====
// Shared types and constants of the button debounce / gesture unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bdg_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int TIME_W      = 32;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_LONG      = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT    = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE    = CFG_INDEX_W'(3);

	// register reset values
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = CFG_DATA_W'(25);
	localparam logic [CFG_DATA_W-1:0] LONG_RST     = CFG_DATA_W'(600);
	localparam logic [CFG_DATA_W-1:0] REPEAT_RST   = CFG_DATA_W'(200);
	localparam logic [CFG_DATA_W-1:0] DOUBLE_RST   = CFG_DATA_W'(300);

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_SINGLE  = 3'd2,
		EV_DOUBLE  = 3'd3,
		EV_LSTART  = 3'd4,
		EV_HOLD    = 3'd5,
		EV_LSTOP   = 3'd6
	} bdg_event_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              raw_pressed;
	} bdg_in_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic       last_event;
	} bdg_out_t;

	// events caused by one tick; ev1 is meaningful only when two is set
	typedef struct packed {
		logic       two;
		bdg_event_t ev0;
		bdg_event_t ev1;
	} bdg_pair_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdg_front.sv =====
// Front end: config registers, debounce and gesture state machine.
// Classifies each tick into zero, one or two events. Depends on bdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdg_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bdg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bdg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             tick_en,
	input  bdg_pkg::bdg_in_t                 tick,
	output logic                             pair_push,
	output bdg_pkg::bdg_pair_t               pair
);
	import bdg_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_HOLD    = 2'd2,
		PH_WAIT    = 2'd3
	} phase_t;

	logic [CFG_DATA_W-1:0] debounce_ms_q, long_press_ms_q, hold_repeat_ms_q, double_press_ms_q;

	logic              last_raw_q, stable_q, long_done_q, dbl_pend_q;
	logic [TIME_W-1:0] change_time_q, press_time_q, release_time_q, hold_time_q;
	phase_t            phase_q;

	logic              last_raw_n, stable_n, long_done_n, dbl_pend_n;
	logic [TIME_W-1:0] change_time_n, press_time_n, release_time_n, hold_time_n;
	phase_t            phase_n;

	logic              commit, press_edge, up_edge;
	logic [TIME_W-1:0] now;
	logic [TIME_W-1:0] d_change, d_press, d_hold, d_release;
	logic [1:0]        n_ev;
	bdg_event_t        ev0, ev1;

	assign now       = tick.now_ms;
	// a raw change restarts the debounce timer in this very tick
	assign d_change  = (tick.raw_pressed != last_raw_q) ? '0 : now - change_time_q;
	assign d_press   = now - press_time_q;
	assign d_hold    = now - hold_time_q;
	assign d_release = now - release_time_q;

	always_comb begin
		last_raw_n     = last_raw_q;
		change_time_n  = change_time_q;
		stable_n       = stable_q;
		press_time_n   = press_time_q;
		release_time_n = release_time_q;
		hold_time_n    = hold_time_q;
		long_done_n    = long_done_q;
		dbl_pend_n     = dbl_pend_q;
		phase_n        = phase_q;
		n_ev           = 2'd0;
		ev0            = EV_PRESS;
		ev1            = EV_PRESS;

		// debounce: restart the timer on every raw change
		if (tick.raw_pressed != last_raw_q) begin
			last_raw_n    = tick.raw_pressed;
			change_time_n = now;
		end
		commit     = (d_change >= TIME_W'(debounce_ms_q)) && (tick.raw_pressed != stable_q);
		press_edge = commit && tick.raw_pressed;
		up_edge    = commit && !tick.raw_pressed;
		if (commit) begin
			stable_n = tick.raw_pressed;
		end

		if (press_edge) begin
			ev0          = EV_PRESS;
			n_ev         = 2'd1;
			press_time_n = now;
			long_done_n  = 1'b0;
			dbl_pend_n   = (phase_q == PH_WAIT);
			phase_n      = PH_PRESSED;
			// zero long-press time: long start in the same tick
			if (long_press_ms_q == '0) begin
				ev1         = EV_LSTART;
				n_ev        = 2'd2;
				long_done_n = 1'b1;
				phase_n     = PH_HOLD;
				hold_time_n = now;
			end
		end else if (up_edge) begin
			ev0  = EV_RELEASE;
			n_ev = 2'd1;
			case (phase_q)
				PH_HOLD: begin
					ev1        = EV_LSTOP;
					n_ev       = 2'd2;
					phase_n    = PH_IDLE;
					dbl_pend_n = 1'b0;
				end
				PH_PRESSED: begin
					if (dbl_pend_q) begin
						ev1        = EV_DOUBLE;
						n_ev       = 2'd2;
						phase_n    = PH_IDLE;
						dbl_pend_n = 1'b0;
					end else if (double_press_ms_q == '0) begin
						// window of zero closes at once
						ev1            = EV_SINGLE;
						n_ev           = 2'd2;
						phase_n        = PH_IDLE;
						release_time_n = now;
					end else begin
						phase_n        = PH_WAIT;
						release_time_n = now;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end else begin
			case (phase_q)
				PH_PRESSED: begin
					if (!long_done_q && d_press >= TIME_W'(long_press_ms_q)) begin
						ev0         = EV_LSTART;
						n_ev        = 2'd1;
						long_done_n = 1'b1;
						phase_n     = PH_HOLD;
						hold_time_n = now;
					end
				end
				PH_HOLD: begin
					if (d_hold >= TIME_W'(hold_repeat_ms_q)) begin
						ev0         = EV_HOLD;
						n_ev        = 2'd1;
						hold_time_n = now;
					end
				end
				PH_WAIT: begin
					if (d_release >= TIME_W'(double_press_ms_q)) begin
						ev0     = EV_SINGLE;
						n_ev    = 2'd1;
						phase_n = PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign pair_push = tick_en && (n_ev != 2'd0);
	assign pair.two  = n_ev[1];
	assign pair.ev0  = ev0;
	assign pair.ev1  = ev1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q     <= DEBOUNCE_RST;
			long_press_ms_q   <= LONG_RST;
			hold_repeat_ms_q  <= REPEAT_RST;
			double_press_ms_q <= DOUBLE_RST;
			last_raw_q        <= 1'b0;
			stable_q          <= 1'b0;
			change_time_q     <= '0;
			press_time_q      <= '0;
			release_time_q    <= '0;
			hold_time_q       <= '0;
			long_done_q       <= 1'b0;
			dbl_pend_q        <= 1'b0;
			phase_q           <= PH_IDLE;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DEBOUNCE: debounce_ms_q     <= cfg_data;
					REG_LONG:     long_press_ms_q   <= cfg_data;
					REG_REPEAT:   hold_repeat_ms_q  <= cfg_data;
					REG_DOUBLE:   double_press_ms_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (tick_en) begin
				last_raw_q     <= last_raw_n;
				stable_q       <= stable_n;
				change_time_q  <= change_time_n;
				press_time_q   <= press_time_n;
				release_time_q <= release_time_n;
				hold_time_q    <= hold_time_n;
				long_done_q    <= long_done_n;
				dbl_pend_q     <= dbl_pend_n;
				phase_q        <= phase_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bdg_queue.sv =====
// Short FIFO of event pairs between the front end and the result side.
// Depends on bdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdg_queue #(
	parameter int DEPTH = bdg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  bdg_pkg::bdg_pair_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output bdg_pkg::bdg_pair_t rd_data,
	output logic               valid
);
	import bdg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bdg_pair_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bdg_back.sv =====
// Back end: splits each queued event pair into single result words.
// Depends on bdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  bdg_pkg::bdg_pair_t head,
	output logic               head_pop,
	output logic               empty,
	input  logic               pop,
	output bdg_pkg::bdg_out_t  gesture
);
	import bdg_pkg::*;

	logic second_q;
	logic is_last;

	assign is_last            = second_q || !head.two;
	assign empty              = !head_valid;
	assign gesture.event_code = second_q ? head.ev1 : head.ev0;
	assign gesture.last_event = is_last;
	assign head_pop           = pop && head_valid && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (pop && head_valid) begin
			second_q <= !is_last;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/button_debounce_gesture_detector_unit.sv =====
// Each accepted tick's events are registered in the event queue and reach the result side from its head.
// Throughput: one tick per cycle while the event queue has room; one word per cycle out while pop is held.
// A tick makes 0 to 2 words, so output pops set the long-run rate when ticks are busy.
// Reset (arst_n low, async): registers to defaults, button released, phase idle,
// event queue empty. No clearing pass; ticks are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_gesture_detector_unit #(
	parameter int QUEUE_DEPTH = bdg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             cfg_wr_en,
	input  logic [bdg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bdg_pkg::CFG_DATA_W-1:0]   cfg_data,
	// tick input, queue style
	input  logic                             push,
	output logic                             full,
	input  bdg_pkg::bdg_in_t                 tick,
	// result output, queue style
	output logic                             empty,
	input  logic                             pop,
	output bdg_pkg::bdg_out_t                gesture
);
	import bdg_pkg::*;

	logic      tick_en;
	logic      pair_push;
	bdg_pair_t pair;
	logic      head_valid;
	bdg_pair_t head;
	logic      head_pop;

	// a tick is taken whenever the queue can hold its events; the front end
	// updates its state every accepted tick even when no event comes out
	assign tick_en = push && !full;

	// front: debounce, gesture phases and config registers
	bdg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick_en   (tick_en),
		.tick      (tick),
		.pair_push (pair_push),
		.pair      (pair)
	);

	// one entry per tick that produced events; full here stalls the tick side
	bdg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pair_push),
		.wr_data (pair),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head),
		.valid   (head_valid)
	);

	// back: hands out the one or two words of the head entry, marks the last
	bdg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.gesture    (gesture)
	);

endmodule

`default_nettype wire

// ===== rtl/core/bdg_checker.sv =====
// Port-level checker for the button gesture unit, bound to the top level.
// Depends on bdg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "button_debounce_gesture_detector_unit_macros.svh"

module bdg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_wr_en,
	input logic [bdg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input logic [bdg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input logic                             push,
	input logic                             full,
	input bdg_pkg::bdg_in_t                 tick,
	input logic                             empty,
	input logic                             pop,
	input bdg_pkg::bdg_out_t                gesture
);
	import bdg_pkg::*;

	logic cfg_seen;
	assign cfg_seen = cfg_wr_en && (cfg_index == REG_DEBOUNCE) && (cfg_data == '0) && push &&
		tick.raw_pressed;

	// a stalled word stays put
	`BDG_ASSERT_NEXT(a_hold_word, !empty && !pop, !empty && $stable(gesture), "word changed while stalled")
	// a word that is not last is followed by the rest of its tick
	`BDG_ASSERT_NEXT(a_pair_rest, !empty && pop && !gesture.last_event, !empty, "second word missing")
	// only press or release can open a two-word tick
	`BDG_ASSERT_NOW(a_first_kind, !empty && !gesture.last_event || cfg_seen && !empty && !gesture.last_event, gesture.event_code == EV_PRESS || gesture.event_code == EV_RELEASE, "bad first word of pair")
	// no code beyond long stop
	`BDG_ASSERT_NOW(a_code_range, !empty, gesture.event_code <= EV_LSTOP, "undefined event code")
	// without a pop nothing leaves, so full persists
	`BDG_ASSERT_NEXT(a_full_stays, full && !pop, full, "queue drained without pop")

endmodule

bind button_debounce_gesture_detector_unit bdg_checker u_bdg_checker (.*);

`default_nettype wire
